// ----- sv/itoa_pkg.sv -----
package itoa_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int RADIX_W         = 6;
   localparam int CHAR_W          = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

   localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'd48;
   localparam logic [CHAR_W-1:0] ALPHA_GAP  = 8'd39;
   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

   // force the radix into the range 2 to 36
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   // digit value to lowercase ASCII
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      c = {{(CHAR_W-RADIX_W){1'b0}}, d} + ZERO_CHAR;
      if (d > 6'd9) begin
         c = c + ALPHA_GAP;
      end
      return c;
   endfunction

endpackage

// ----- sv/integer_to_ascii_any_base_top.sv -----
// Converts a two's complement value to ASCII digits in a radix from 2 to 36 (values outside
// are clamped), most significant digit first, one character per rsp transfer, tlast on the
// final one. Base 10 negatives get a leading '-'; the most negative value always comes out as
// its decimal text. Per item the request is taken, then a bit-serial long division with a
// 6-bit remainder, one magnitude bit per cycle, runs one pass per digit, the first pass over
// all W = VALUE_WIDTH bits and each later pass one bit shorter; then a sign state if needed,
// then per digit character a fetch state (registered read of the digit memory) and a send
// state that waits until the output register is free.
// A new request is taken as soon as the last character sits in the output register.
module integer_to_ascii_any_base_top #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
   localparam int REQ_DATA_W = ((VALUE_WIDTH + itoa_pkg::RADIX_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_DATA_W-1:0]       req_tdata,   // value, radix, zero pad
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [itoa_pkg::CHAR_W-1:0] rsp_tdata,   // char_out
   output logic                        rsp_tlast    // last
);

   localparam int RW    = itoa_pkg::RADIX_W;
   localparam int NB_W  = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_W = $clog2(VALUE_WIDTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_SIGN  = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_SEND  = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [VALUE_WIDTH-1:0]      mag_ff, mag_in;
   logic [RW-1:0]               radix_ff, radix_in;
   logic                        neg_ff, neg_in;
   logic [RW-1:0]               rem_ff, rem_in;
   logic [NB_W-1:0]             nbits_ff, nbits_in;
   logic [NB_W-1:0]             cyc_ff, cyc_in;
   logic [NB_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]            ptr_ff, ptr_in;
   logic [RW-1:0]               rd_ff;
   logic [RW-1:0]               digit_store_ff [VALUE_WIDTH];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_W-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_xfer;
   logic                        out_free;
   logic                        store_we;
   logic [VALUE_WIDTH-1:0]      req_value;
   logic [VALUE_WIDTH-1:0]      req_mag;
   logic                        req_neg;
   logic                        req_min;
   logic [RW-1:0]               req_radix;
   logic [RW:0]                 rem_wide;
   logic                        rem_ge;
   logic [RW-1:0]               rem_step;
   logic [NB_W-1:0]             ins_pos;
   logic                        pass_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_value = req_tdata[VALUE_WIDTH-1:0];
   assign req_radix = req_tdata[VALUE_WIDTH+RW-1:VALUE_WIDTH];
   assign req_neg   = req_value[VALUE_WIDTH-1];
   assign req_min   = req_neg && (req_value[VALUE_WIDTH-2:0] == '0);
   assign req_mag   = req_neg ? (~req_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : req_value;

   // one step of restoring division: remainder takes the top magnitude bit
   assign rem_wide = {rem_ff, mag_ff[VALUE_WIDTH-1]};
   assign rem_ge   = (rem_wide >= {1'b0, radix_ff});
   assign rem_step = rem_ge ? RW'(rem_wide - {1'b0, radix_ff}) : rem_wide[RW-1:0];
   assign ins_pos  = NB_W'(VALUE_WIDTH) - nbits_ff + NB_W'(1);
   assign pass_end = (cyc_ff == nbits_ff - NB_W'(1));
   assign store_we = (state_ff == ST_DIV) && pass_end;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      nbits_in     = nbits_ff;
      cyc_in       = cyc_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mag_in   = req_mag;
               neg_in   = req_neg;
               radix_in = req_min ? itoa_pkg::RADIX_DEC
                                  : itoa_pkg::clamp_radix(req_radix);
               rem_in   = '0;
               nbits_in = NB_W'(VALUE_WIDTH);
               cyc_in   = '0;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_step;
            mag_in = mag_ff << 1;
            // the first quotient bit of a pass is always zero: drop it, so the
            // quotient ends up left aligned one bit narrower
            if (cyc_ff != '0) begin
               for (int i = 0; i < VALUE_WIDTH; i++) begin
                  if (ins_pos == NB_W'(i)) begin
                     mag_in[i] = rem_ge;
                  end
               end
            end
            cyc_in = cyc_ff + NB_W'(1);
            if (pass_end) begin
               count_in = count_ff + NB_W'(1);
               rem_in   = '0;
               cyc_in   = '0;
               nbits_in = nbits_ff - NB_W'(1);
               if (mag_in == '0) begin
                  ptr_in   = count_ff[IDX_W-1:0];
                  state_in = (neg_ff && radix_ff == itoa_pkg::RADIX_DEC) ? ST_SIGN : ST_FETCH;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = itoa_pkg::MINUS_CHAR;
               rsp_last_in  = 1'b0;
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = itoa_pkg::digit_char(rd_ff);
               rsp_last_in  = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= itoa_pkg::RADIX_MIN;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         nbits_ff     <= NB_W'(VALUE_WIDTH);
         cyc_ff       <= '0;
         rem_ff       <= '0;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         radix_ff     <= radix_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         nbits_ff     <= nbits_in;
         cyc_ff       <= cyc_in;
         rem_ff       <= rem_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit memory: least significant digit at index zero
   always_ff @(posedge clock) begin
      if (store_we) begin
         digit_store_ff[count_ff[IDX_W-1:0]] <= rem_step;
      end
      rd_ff <= digit_store_ff[ptr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < radix_ff)
      else $error("division remainder reached the radix");

   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |->
         (radix_ff >= itoa_pkg::RADIX_MIN && radix_ff <= itoa_pkg::RADIX_MAX))
      else $error("working radix out of range");

   a_ptr_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_SEND) |-> {1'b0, ptr_ff} < count_ff)
      else $error("digit pointer beyond stored digits");
`endif

endmodule
